FILE: hw/rtl/tmpd_pkg.sv
package tmpd_pkg;

   localparam int DATA_W            = 16;
   localparam int BURST_SAMPLES_DEF = 10;
   localparam int HISTORY_DEPTH_DEF = 8;

   // rank window as a fraction of the burst: [3/10, 7/10)
   localparam int RANK_LO_NUM = 3;
   localparam int RANK_HI_NUM = 7;
   localparam int RANK_DEN    = 10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_TSTART,
      ST_TWAIT,
      ST_BSTART,
      ST_BWAIT,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic ready;
      logic insert;
      logic restart;
      logic sum_start;
      logic sum_step;
      logic div_start;
      logic div_base;
      logic tmean_load;
      logic base_load;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic burst_last;
      logic sum_last;
      logic div_done;
      logic rsp_busy;
   } sts_type;

endpackage

FILE: hw/rtl/tmpd_req_if.sv
interface tmpd_req_if;
   logic                          valid;
   logic                          ready;
   logic [tmpd_pkg::DATA_W-1:0]   raw_count;
   logic                          restart;

   modport source (output valid, raw_count, restart, input ready);
   modport sink (input valid, raw_count, restart, output ready);
endinterface

FILE: hw/rtl/tmpd_rsp_if.sv
interface tmpd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tmpd_pkg::DATA_W-1:0]   trimmed_mean;
   logic [tmpd_pkg::DATA_W-1:0]   baseline_mean;
   logic                          presence;

   modport source (output valid, trimmed_mean, baseline_mean, presence, input ready);
   modport sink (input valid, trimmed_mean, baseline_mean, presence, output ready);
endinterface

FILE: hw/rtl/trimmed_mean_presence_detector.sv
// A word that does not end a burst, or a restart, is taken in idle; the next is taken at once.
// A burst-ending word gives its result after the rank sum (one word a cycle) and two reciprocal
// divisions in turn; the commit waits while the previous result still waits in the result register.
// Throughput: one word per cycle inside a burst; no word is taken while a burst end is processed.
// Reset (synchronous, active high) clears burst count, fill count, ring pointer, history sum,
// history valid bits, threshold and the result register; the ring reads as zero until written.
module trimmed_mean_presence_detector #(
   parameter int BURST_SAMPLES = tmpd_pkg::BURST_SAMPLES_DEF,
   parameter int HISTORY_DEPTH = tmpd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   tmpd_req_if.sink                    req_if,
   tmpd_rsp_if.source                  rsp_if,
   input  logic                        csr_wr_en,
   input  logic [tmpd_pkg::DATA_W-1:0] csr_wr_data
);

   // command and status between sequencer and datapath
   tmpd_pkg::cmd_type cmd;
   tmpd_pkg::sts_type sts;

   // sequencer: takes words in idle, then walks sum, divisions and commit
   tmpd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_restart (req_if.restart),
      .sts         (sts),
      .cmd         (cmd)
   );

   // datapath: sorted burst kept on the fly, so the burst end only sums the middle ranks
   tmpd_dp #(
      .BURST_SAMPLES (BURST_SAMPLES),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .raw_count     (req_if.raw_count),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .trimmed_mean  (rsp_if.trimmed_mean),
      .baseline_mean (rsp_if.baseline_mean),
      .presence      (rsp_if.presence)
   );

   // ready comes from the sequencer; a held result blocks new words only while a burst end waits to commit
   assign req_if.ready = cmd.ready;

   // commit never overwrites a result still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_if.valid && !rsp_if.ready))
      else $error("commit while result pending");

   // a result word appears only from a commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.commit))
      else $error("result without commit");

   // presence needs the mean strictly above baseline
   a_presence_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.presence) |-> (rsp_if.trimmed_mean > rsp_if.baseline_mean))
      else $error("presence with mean not above baseline");

   // burst processing blocks new words
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.sum_start |=> !req_if.ready)
      else $error("ready during burst processing");

endmodule

FILE: hw/rtl/tmpd_div.sv
// divide by a constant: reciprocal multiply, quotient registered in the cycle after start
module tmpd_div #(
   parameter int DVD_W   = 20,
   parameter int QUO_W   = 16,
   parameter int DIVISOR = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   output logic [QUO_W-1:0] quotient,
   output logic             done
);

   // floor(x / d) = (x * ceil(2^(DVD_W+l) / d)) >> (DVD_W+l), l = ceil(log2 d);
   // exact for every x below 2^DVD_W, and the factor fits DVD_W+1 bits
   localparam int     SHIFT = DVD_W + $clog2(DIVISOR);
   localparam int     MUL_W = DVD_W + 1;
   localparam int     PRD_W = DVD_W + MUL_W;
   localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(DIVISOR - 1)) /
                              longint'(DIVISOR);
   localparam logic [MUL_W-1:0] MUL = MUL_W'(RECIP);

   logic             done_ff;
   logic [PRD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= {{MUL_W{1'b0}}, dividend} * {{DVD_W{1'b0}}, MUL};
      end
   end

   assign quotient = QUO_W'(prod_ff >> SHIFT);
   assign done     = done_ff;

endmodule

FILE: hw/rtl/tmpd_dp.sv
// datapath: insertion sorter, rank sum, history ring, two dividers, threshold, result register
module tmpd_dp #(
   parameter int BURST_SAMPLES = tmpd_pkg::BURST_SAMPLES_DEF,
   parameter int HISTORY_DEPTH = tmpd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tmpd_pkg::cmd_type           cmd,
   output tmpd_pkg::sts_type           sts,
   input  logic [tmpd_pkg::DATA_W-1:0] raw_count,
   input  logic                        csr_wr_en,
   input  logic [tmpd_pkg::DATA_W-1:0] csr_wr_data,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [tmpd_pkg::DATA_W-1:0] trimmed_mean,
   output logic [tmpd_pkg::DATA_W-1:0] baseline_mean,
   output logic                        presence
);

   localparam int DW      = tmpd_pkg::DATA_W;
   localparam int RANK_LO = BURST_SAMPLES * tmpd_pkg::RANK_LO_NUM / tmpd_pkg::RANK_DEN;
   localparam int RANK_HI = BURST_SAMPLES * tmpd_pkg::RANK_HI_NUM / tmpd_pkg::RANK_DEN;
   localparam int TCOUNT  = RANK_HI - RANK_LO;
   localparam int CNT_W   = $clog2(BURST_SAMPLES + 1);
   localparam int IDX_W   = $clog2(BURST_SAMPLES);
   localparam int TSUM_W  = DW + $clog2(TCOUNT + 1);
   localparam int HSUM_W  = DW + $clog2(HISTORY_DEPTH + 1);
   localparam int PTR_W   = $clog2(HISTORY_DEPTH);
   localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);

   // sorted burst, valid below count_ff
   logic [DW-1:0]            sort_ff [BURST_SAMPLES];
   logic [DW-1:0]            sort_in [BURST_SAMPLES];
   logic [BURST_SAMPLES-1:0] gt;
   logic [CNT_W-1:0]         count_ff;

   logic [IDX_W-1:0]         idx_ff;
   logic [TSUM_W-1:0]        tsum_ff;

   logic [DW-1:0]            hist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] hist_vld_ff;
   logic [DW-1:0]            rd_data_ff;
   logic [DW-1:0]            old_entry;
   logic [PTR_W-1:0]         ptr_ff;
   logic [HSUM_W-1:0]        hsum_ff;
   logic [FILL_W-1:0]        fill_ff;
   logic [FILL_W-1:0]        fill_next;

   logic [DW-1:0]            thr_ff;
   logic [DW-1:0]            tmean_ff;
   logic [DW-1:0]            base_ff;

   logic                     tdiv_start;
   logic                     bdiv_start;
   logic [DW-1:0]            tdiv_quot;
   logic [DW-1:0]            bdiv_quot;
   logic                     tdiv_done;
   logic                     bdiv_done;

   logic [DW:0]              limit;
   logic                     pres_in;

   logic                     rsp_valid_ff;
   logic [DW-1:0]            rsp_tmean_ff;
   logic [DW-1:0]            rsp_base_ff;
   logic                     rsp_pres_ff;

   // one cell per rank: take the left neighbour, the new word, or hold
   always_comb begin
      for (int i = 0; i < BURST_SAMPLES; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (sort_ff[i] > raw_count);
      end
      sort_in[0] = (gt[0] || count_ff == '0) ? raw_count : sort_ff[0];
      for (int i = 1; i < BURST_SAMPLES; i++) begin
         if (gt[i-1]) begin
            sort_in[i] = sort_ff[i-1];
         end else if (gt[i] || CNT_W'(i) == count_ff) begin
            sort_in[i] = raw_count;
         end else begin
            sort_in[i] = sort_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         for (int i = 0; i < BURST_SAMPLES; i++) begin
            sort_ff[i] <= sort_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.restart) begin
         count_ff <= '0;
      end else if (cmd.insert) begin
         count_ff <= sts.burst_last ? '0 : count_ff + CNT_W'(1);
      end
   end

   // rank window sum, one word a cycle
   always_ff @(posedge clock) begin
      if (cmd.sum_start) begin
         idx_ff  <= IDX_W'(RANK_LO);
         tsum_ff <= '0;
      end else if (cmd.sum_step) begin
         idx_ff  <= idx_ff + IDX_W'(1);
         tsum_ff <= tsum_ff + TSUM_W'(sort_ff[idx_ff]);
      end
   end

   always_comb begin
      tdiv_start = cmd.div_start && !cmd.div_base;
      bdiv_start = cmd.div_start && cmd.div_base;
   end

   // rank sum over the window size
   tmpd_div #(
      .DVD_W   (TSUM_W),
      .QUO_W   (DW),
      .DIVISOR (TCOUNT)
   ) u_tdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (tdiv_start),
      .dividend (tsum_ff),
      .quotient (tdiv_quot),
      .done     (tdiv_done)
   );

   // history sum over the ring depth
   tmpd_div #(
      .DVD_W   (HSUM_W),
      .QUO_W   (DW),
      .DIVISOR (HISTORY_DEPTH)
   ) u_bdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (bdiv_start),
      .dividend (hsum_ff),
      .quotient (bdiv_quot),
      .done     (bdiv_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.tmean_load) begin
         tmean_ff <= tdiv_quot;
      end
      if (cmd.base_load) begin
         base_ff <= bdiv_quot;
      end
   end

   // history ring
   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[ptr_ff];
      if (cmd.commit) begin
         hist_mem[ptr_ff] <= tmean_ff;
      end
   end

   assign old_entry = hist_vld_ff[ptr_ff] ? rd_data_ff : '0;
   assign fill_next = (fill_ff == FILL_W'(HISTORY_DEPTH)) ? fill_ff : fill_ff + FILL_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         ptr_ff      <= '0;
         hsum_ff     <= '0;
         fill_ff     <= '0;
      end else if (cmd.restart) begin
         fill_ff <= '0;
      end else if (cmd.commit) begin
         hist_vld_ff[ptr_ff] <= 1'b1;
         ptr_ff  <= (ptr_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);
         hsum_ff <= hsum_ff + HSUM_W'(tmean_ff) - HSUM_W'(old_entry);
         fill_ff <= fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   always_comb begin
      limit   = {1'b0, base_ff} + {1'b0, thr_ff};
      pres_in = (fill_next == FILL_W'(HISTORY_DEPTH)) && ({1'b0, tmean_ff} > limit);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_tmean_ff <= tmean_ff;
         rsp_base_ff  <= base_ff;
         rsp_pres_ff  <= pres_in;
      end
   end

   always_comb begin
      sts.burst_last = count_ff == CNT_W'(BURST_SAMPLES - 1);
      sts.sum_last   = idx_ff == IDX_W'(RANK_HI - 1);
      sts.div_done   = tdiv_done || bdiv_done;
      sts.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign trimmed_mean  = rsp_tmean_ff;
   assign baseline_mean = rsp_base_ff;
   assign presence      = rsp_pres_ff;

endmodule

FILE: hw/rtl/tmpd_ctrl.sv
// sequencer: takes words in idle; at burst end, sum, two divisions, commit
module tmpd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_restart,
   input  tmpd_pkg::sts_type sts,
   output tmpd_pkg::cmd_type cmd
);

   tmpd_pkg::state_type state_ff;
   tmpd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmpd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         tmpd_pkg::ST_IDLE: begin
            cmd.ready = 1'b1;
            if (req_valid) begin
               if (req_restart) begin
                  cmd.restart = 1'b1;
               end else begin
                  cmd.insert = 1'b1;
                  if (sts.burst_last) begin
                     cmd.sum_start = 1'b1;
                     state_in      = tmpd_pkg::ST_SUM;
                  end
               end
            end
         end
         tmpd_pkg::ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (sts.sum_last) begin
               state_in = tmpd_pkg::ST_TSTART;
            end
         end
         tmpd_pkg::ST_TSTART: begin
            cmd.div_start = 1'b1;
            state_in      = tmpd_pkg::ST_TWAIT;
         end
         tmpd_pkg::ST_TWAIT: begin
            if (sts.div_done) begin
               cmd.tmean_load = 1'b1;
               state_in       = tmpd_pkg::ST_BSTART;
            end
         end
         tmpd_pkg::ST_BSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_base  = 1'b1;
            state_in      = tmpd_pkg::ST_BWAIT;
         end
         tmpd_pkg::ST_BWAIT: begin
            if (sts.div_done) begin
               cmd.base_load = 1'b1;
               state_in      = tmpd_pkg::ST_UPDATE;
            end
         end
         tmpd_pkg::ST_UPDATE: begin
            if (!sts.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = tmpd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tmpd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
